@@ design/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define SCS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/scs_pkg.sv @@
package scs_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int INDEX_BITS_DEF  = 32;
    localparam int VALUE_BITS_DEF  = 16;

    localparam int MUL_BITS    = 32;
    localparam int ACC_BITS    = 48;
    localparam int COS_BITS    = 16;
    localparam int COUNT_BITS  = 11;
    localparam int CFG_BITS    = 16;
    localparam int WIDE_BITS   = 128;
    localparam int WX_BITS     = 3 * MUL_BITS;
    localparam int WY_BITS     = 2 * MUL_BITS;
    localparam int PP_COUNT    = 6;
    localparam int D_SHIFT     = 30;
    localparam int SEARCH_BITS = 16;

    typedef logic [1:0]                  func_t;
    typedef logic [1:0]                  status_t;
    typedef logic signed [ACC_BITS-1:0]  dot_t;
    typedef logic [ACC_BITS-1:0]         norm_t;
    typedef logic signed [COS_BITS-1:0]  cos_t;
    typedef logic [COUNT_BITS-1:0]       count_t;
    typedef logic [CFG_BITS-1:0]         cfg_t;
    typedef logic [WIDE_BITS-1:0]        wide_t;
    typedef logic [MUL_BITS-1:0]         mul_op_t;
    typedef logic [2*MUL_BITS-1:0]       mul_prod_t;

    localparam func_t FUNC_LOAD_A = 2'd0;
    localparam func_t FUNC_LOAD_B = 2'd1;
    localparam func_t FUNC_FINISH = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_ZERO_NORM = 2'd1;
    localparam status_t ST_ORDER     = 2'd2;
    localparam status_t ST_OVERFLOW  = 2'd3;

    localparam dot_t  DOT_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam dot_t  DOT_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam norm_t NORM_MAX = '1;

    localparam logic [SEARCH_BITS-1:0] COS_ONE = SEARCH_BITS'(1) << (SEARCH_BITS - 1);
    localparam cos_t COS_MAX = {1'b0, {(COS_BITS-1){1'b1}}};

    localparam cfg_t MIN_NORM_RESET = CFG_BITS'(1);

endpackage

@@ design/scs_if.sv @@
interface scs_item_if #(
    parameter int INDEX_BITS = scs_pkg::INDEX_BITS_DEF,
    parameter int VALUE_BITS = scs_pkg::VALUE_BITS_DEF
);
    import scs_pkg::*;

    logic                         valid;
    logic                         ready;
    func_t                        func;
    logic [INDEX_BITS-1:0]        entry_index;
    logic signed [VALUE_BITS-1:0] entry_value;

    modport source (output valid, func, entry_index, entry_value, input ready);
    modport sink (input valid, func, entry_index, entry_value, output ready);
endinterface

interface scs_result_if;
    import scs_pkg::*;

    logic    valid;
    logic    ready;
    dot_t    dot_product;
    cos_t    cosine;
    count_t  count_a;
    count_t  count_b;
    status_t status;

    modport source (output valid, dot_product, cosine, count_a, count_b, status, input ready);
    modport sink (input valid, dot_product, cosine, count_a, count_b, status, output ready);
endinterface

@@ design/scs_mul.sv @@
module scs_mul (
    input  logic               clk,
    input  scs_pkg::mul_op_t   op_a,
    input  scs_pkg::mul_op_t   op_b,
    output scs_pkg::mul_prod_t prod
);
    import scs_pkg::*;

    mul_prod_t prod_reg;

    // unsigned 32x32, product registered
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod_t'(op_a) * mul_prod_t'(op_b);
    end

    assign prod = prod_reg;

endmodule

@@ design/scs_store.sv @@
module scs_store #(
    parameter int DEPTH      = scs_pkg::MAX_ENTRIES_DEF,
    parameter int INDEX_BITS = scs_pkg::INDEX_BITS_DEF,
    parameter int VALUE_BITS = scs_pkg::VALUE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [INDEX_BITS-1:0]    wr_index,
    input  logic [VALUE_BITS-1:0]    wr_value,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [INDEX_BITS-1:0]    rd_index,
    output logic [VALUE_BITS-1:0]    rd_value
);
    import scs_pkg::*;

    localparam int ENTRY_BITS = INDEX_BITS + VALUE_BITS;

    logic [ENTRY_BITS-1:0] mem [DEPTH];
    logic [ENTRY_BITS-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wr_index, wr_value};
        end
        rd_reg <= mem[raddr];
    end

    assign rd_index = rd_reg[ENTRY_BITS-1:VALUE_BITS];
    assign rd_value = rd_reg[VALUE_BITS-1:0];

endmodule

@@ design/sparse_cosine_similarity_core.sv @@
// load a: S_SQ then S_NORM per word; stream b: S_MREQ and S_MCMP per a entry skipped, S_DOT on a match,
// then S_SQ and S_NORM; dropped word: straight back to idle; finish: two products of 6 partial products,
// then 16 search steps on the one shared 32x32 multiplier; low norm skips to emit; not ready meanwhile
// the result sits in an output register so loads and streams go on while it waits
// reset is asynchronous and clears counts, sums, error code and sets min_norm_squared to 1
// the entry store is not cleared; only entries written since are ever read
`include "assert_macros.svh"

module sparse_cosine_similarity_core #(
    parameter int MAX_ENTRIES = scs_pkg::MAX_ENTRIES_DEF,
    parameter int INDEX_BITS  = scs_pkg::INDEX_BITS_DEF,
    parameter int VALUE_BITS  = scs_pkg::VALUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    scs_item_if.sink      item,
    scs_result_if.source  result,
    input  logic          cfg_we,
    input  scs_pkg::cfg_t cfg_wdata
);
    import scs_pkg::*;

    localparam int ADDR_BITS  = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
    localparam int DSUM_BITS  = 2 * MUL_BITS + 2;
    localparam int NSUM_BITS  = 2 * MUL_BITS + 1;
    localparam int SBIT_BITS  = $clog2(SEARCH_BITS);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(MAX_ENTRIES);
    localparam logic [2:0] PP_LAST = 3'(PP_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MREQ, S_MCMP, S_DOT, S_SQ, S_NORM, S_FCHK, S_WMUL,
        S_WDRAIN, S_FD, S_FP, S_TSQ, S_TSQ2, S_TCMP, S_COS, S_EMIT
    } state_t;

    state_t                  state_reg, ret_reg;
    func_t                   func_reg;
    logic [INDEX_BITS-1:0]   idx_reg, prev_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic [CNT_BITS-1:0]     a_count_reg, b_count_reg, ptr_reg;
    dot_t                    dot_reg;
    norm_t                   norm_a_reg, norm_b_reg;
    status_t                 err_reg, st_reg;
    cfg_t                    min_norm_reg;
    logic                    dneg_reg;
    logic [WX_BITS-1:0]      wx_reg, p_reg;
    logic [WY_BITS-1:0]      wy_reg;
    wide_t                   acc_reg, d_reg;
    logic [2:0]              pp_cnt_reg;
    logic                    pp_valid_reg;
    logic [1:0]              pp_shift_reg;
    logic [SEARCH_BITS-1:0]  m_reg;
    logic [SBIT_BITS-1:0]    sbit_reg;
    cos_t                    cos_reg;
    logic                    out_valid_reg;
    dot_t                    out_dot_reg;
    cos_t                    out_cos_reg;
    count_t                  out_ca_reg, out_cb_reg;
    status_t                 out_st_reg;

    logic                    accept;
    logic                    order_err_a, order_err_b;
    logic                    store_we;
    logic [INDEX_BITS-1:0]   rd_index;
    logic [VALUE_BITS-1:0]   rd_value;
    logic [VALUE_BITS-1:0]   val_abs, rd_abs;
    mul_op_t                 mul_a, mul_b;
    mul_prod_t               mul_prod;
    wide_t                   pp_term;
    logic [DSUM_BITS-1:0]    dsum;
    logic                    dsum_fits;
    dot_t                    dot_next;
    logic [NSUM_BITS-1:0]    nsum;
    norm_t                   norm_sel, norm_next;
    norm_t                   dot_mag;
    logic                    low_norm;
    logic [SEARCH_BITS-1:0]  trial;
    logic                    trial_ok;
    logic                    out_free;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    assign order_err_a = (b_count_reg != '0) ||
                         ((a_count_reg != '0) && (item.entry_index <= prev_reg));
    assign order_err_b = (b_count_reg != '0) && (item.entry_index <= prev_reg);
    assign store_we    = accept && (item.func == FUNC_LOAD_A) && !order_err_a &&
                         (a_count_reg != CNT_FULL);

    scs_store #(
        .DEPTH      (MAX_ENTRIES),
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk      (clk),
        .we       (store_we),
        .waddr    (a_count_reg[ADDR_BITS-1:0]),
        .wr_index (item.entry_index),
        .wr_value (item.entry_value),
        .raddr    (ptr_reg[ADDR_BITS-1:0]),
        .rd_index (rd_index),
        .rd_value (rd_value)
    );

    scs_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    assign val_abs = val_reg[VALUE_BITS-1] ? (~val_reg + 1'b1) : val_reg;
    assign rd_abs  = rd_value[VALUE_BITS-1] ? (~rd_value + 1'b1) : rd_value;

    assign trial    = m_reg | (SEARCH_BITS'(1) << sbit_reg);
    assign trial_ok = (trial <= COS_ONE);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MCMP:
            begin
                mul_a = MUL_BITS'(rd_abs);
                mul_b = MUL_BITS'(val_abs);
            end
            S_SQ:
            begin
                mul_a = MUL_BITS'(val_abs);
                mul_b = MUL_BITS'(val_abs);
            end
            S_WMUL:
            begin
                mul_a = wx_reg[MUL_BITS*int'(pp_cnt_reg[2:1]) +: MUL_BITS];
                mul_b = wy_reg[MUL_BITS*int'(pp_cnt_reg[0]) +: MUL_BITS];
            end
            S_TSQ:
            begin
                mul_a = MUL_BITS'(trial);
                mul_b = MUL_BITS'(trial);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pp_term = wide_t'(mul_prod) << (MUL_BITS * int'(pp_shift_reg));

    // saturating dot accumulate
    always_comb
    begin
        dsum = {{(DSUM_BITS-ACC_BITS){dot_reg[ACC_BITS-1]}}, dot_reg};
        if (dneg_reg)
        begin
            dsum = dsum - {2'b00, mul_prod};
        end
        else
        begin
            dsum = dsum + {2'b00, mul_prod};
        end
        dsum_fits = (&dsum[DSUM_BITS-1:ACC_BITS-1]) || !(|dsum[DSUM_BITS-1:ACC_BITS-1]);
        if (dsum_fits)
        begin
            dot_next = dsum[ACC_BITS-1:0];
        end
        else if (dsum[DSUM_BITS-1])
        begin
            dot_next = DOT_MIN;
        end
        else
        begin
            dot_next = DOT_MAX;
        end
    end

    // saturating norm accumulate
    assign norm_sel  = (func_reg == FUNC_LOAD_A) ? norm_a_reg : norm_b_reg;
    assign nsum      = NSUM_BITS'(norm_sel) + NSUM_BITS'(mul_prod);
    assign norm_next = (nsum > NSUM_BITS'(NORM_MAX)) ? NORM_MAX : nsum[ACC_BITS-1:0];

    assign dot_mag  = dot_reg[ACC_BITS-1] ? (~dot_reg + 1'b1) : dot_reg;
    assign low_norm = (norm_a_reg < norm_t'(min_norm_reg)) ||
                      (norm_b_reg < norm_t'(min_norm_reg)) ||
                      (norm_a_reg == '0) || (norm_b_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            func_reg      <= FUNC_LOAD_A;
            idx_reg       <= '0;
            prev_reg      <= '0;
            val_reg       <= '0;
            a_count_reg   <= '0;
            b_count_reg   <= '0;
            ptr_reg       <= '0;
            dot_reg       <= '0;
            norm_a_reg    <= '0;
            norm_b_reg    <= '0;
            err_reg       <= ST_OK;
            st_reg        <= ST_OK;
            min_norm_reg  <= MIN_NORM_RESET;
            dneg_reg      <= 1'b0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            p_reg         <= '0;
            acc_reg       <= '0;
            d_reg         <= '0;
            pp_cnt_reg    <= '0;
            pp_valid_reg  <= 1'b0;
            pp_shift_reg  <= '0;
            m_reg         <= '0;
            sbit_reg      <= '0;
            cos_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_dot_reg   <= '0;
            out_cos_reg   <= '0;
            out_ca_reg    <= '0;
            out_cb_reg    <= '0;
            out_st_reg    <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                min_norm_reg <= cfg_wdata;
            end
            if (result.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            // partial products land in the cycle after their operands
            pp_valid_reg <= (state_reg == S_WMUL);
            pp_shift_reg <= pp_cnt_reg[2:1] + 2'(pp_cnt_reg[0]);
            if (pp_valid_reg)
            begin
                acc_reg <= acc_reg + pp_term;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (item.func)
                            FUNC_LOAD_A:
                            begin
                                if (order_err_a)
                                begin
                                    if (err_reg == ST_OK) err_reg <= ST_ORDER;
                                end
                                else if (a_count_reg == CNT_FULL)
                                begin
                                    if (err_reg == ST_OK) err_reg <= ST_OVERFLOW;
                                end
                                else
                                begin
                                    a_count_reg <= a_count_reg + 1'b1;
                                    prev_reg    <= item.entry_index;
                                    val_reg     <= item.entry_value;
                                    func_reg    <= FUNC_LOAD_A;
                                    state_reg   <= S_SQ;
                                end
                            end
                            FUNC_LOAD_B:
                            begin
                                if (order_err_b)
                                begin
                                    if (err_reg == ST_OK) err_reg <= ST_ORDER;
                                end
                                else if (b_count_reg == CNT_FULL)
                                begin
                                    if (err_reg == ST_OK) err_reg <= ST_OVERFLOW;
                                end
                                else
                                begin
                                    b_count_reg <= b_count_reg + 1'b1;
                                    prev_reg    <= item.entry_index;
                                    idx_reg     <= item.entry_index;
                                    val_reg     <= item.entry_value;
                                    func_reg    <= FUNC_LOAD_B;
                                    state_reg   <= S_MREQ;
                                end
                            end
                            FUNC_FINISH:
                            begin
                                state_reg <= S_FCHK;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MREQ:
                begin
                    if (ptr_reg < a_count_reg)
                    begin
                        state_reg <= S_MCMP;
                    end
                    else
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_MCMP:
                begin
                    if (rd_index < idx_reg)
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= S_MREQ;
                    end
                    else if (rd_index == idx_reg)
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        dneg_reg  <= rd_value[VALUE_BITS-1] ^ val_reg[VALUE_BITS-1];
                        state_reg <= S_DOT;
                    end
                    else
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_DOT:
                begin
                    dot_reg   <= dot_next;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if (func_reg == FUNC_LOAD_A)
                    begin
                        norm_a_reg <= norm_next;
                    end
                    else
                    begin
                        norm_b_reg <= norm_next;
                    end
                    state_reg <= S_IDLE;
                end
                S_FCHK:
                begin
                    if (err_reg != ST_OK)
                    begin
                        st_reg <= err_reg;
                    end
                    else
                    begin
                        st_reg <= low_norm ? ST_ZERO_NORM : ST_OK;
                    end
                    if (low_norm)
                    begin
                        cos_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        // dot squared first
                        wx_reg     <= WX_BITS'(dot_mag);
                        wy_reg     <= WY_BITS'(dot_mag);
                        acc_reg    <= '0;
                        pp_cnt_reg <= '0;
                        ret_reg    <= S_FD;
                        state_reg  <= S_WMUL;
                    end
                end
                S_WMUL:
                begin
                    pp_cnt_reg <= pp_cnt_reg + 1'b1;
                    if (pp_cnt_reg == PP_LAST)
                    begin
                        state_reg <= S_WDRAIN;
                    end
                end
                S_WDRAIN:
                begin
                    state_reg <= ret_reg;
                end
                S_FD:
                begin
                    d_reg      <= acc_reg << D_SHIFT;
                    wx_reg     <= WX_BITS'(norm_a_reg);
                    wy_reg     <= WY_BITS'(norm_b_reg);
                    acc_reg    <= '0;
                    pp_cnt_reg <= '0;
                    ret_reg    <= S_FP;
                    state_reg  <= S_WMUL;
                end
                S_FP:
                begin
                    p_reg     <= acc_reg[WX_BITS-1:0];
                    m_reg     <= '0;
                    sbit_reg  <= SBIT_BITS'(SEARCH_BITS - 1);
                    state_reg <= S_TSQ;
                end
                S_TSQ:
                begin
                    // a trial above one is never taken
                    if (trial_ok)
                    begin
                        state_reg <= S_TSQ2;
                    end
                    else if (sbit_reg == '0)
                    begin
                        state_reg <= S_COS;
                    end
                    else
                    begin
                        sbit_reg <= sbit_reg - 1'b1;
                    end
                end
                S_TSQ2:
                begin
                    wx_reg     <= p_reg;
                    wy_reg     <= mul_prod;
                    acc_reg    <= '0;
                    pp_cnt_reg <= '0;
                    ret_reg    <= S_TCMP;
                    state_reg  <= S_WMUL;
                end
                S_TCMP:
                begin
                    // keep the bit while trial^2 * na * nb <= dot^2 * 2^30
                    if (acc_reg <= d_reg)
                    begin
                        m_reg <= trial;
                    end
                    if (sbit_reg == '0)
                    begin
                        state_reg <= S_COS;
                    end
                    else
                    begin
                        sbit_reg  <= sbit_reg - 1'b1;
                        state_reg <= S_TSQ;
                    end
                end
                S_COS:
                begin
                    if (dot_reg[ACC_BITS-1])
                    begin
                        cos_reg <= cos_t'(~m_reg + 1'b1);
                    end
                    else if (m_reg == COS_ONE)
                    begin
                        cos_reg <= COS_MAX;
                    end
                    else
                    begin
                        cos_reg <= cos_t'(m_reg);
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dot_reg   <= dot_reg;
                        out_cos_reg   <= cos_reg;
                        out_ca_reg    <= count_t'(a_count_reg);
                        out_cb_reg    <= count_t'(b_count_reg);
                        out_st_reg    <= st_reg;
                        a_count_reg   <= '0;
                        b_count_reg   <= '0;
                        ptr_reg       <= '0;
                        prev_reg      <= '0;
                        dot_reg       <= '0;
                        norm_a_reg    <= '0;
                        norm_b_reg    <= '0;
                        err_reg       <= ST_OK;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.dot_product = out_dot_reg;
    assign result.cosine      = out_cos_reg;
    assign result.count_a     = out_ca_reg;
    assign result.count_b     = out_cb_reg;
    assign result.status      = out_st_reg;

    `SCS_ASSERT_ALWAYS(a_ptr_bound, clk, rst_n, ptr_reg <= a_count_reg, "merge pointer past loaded entries")
    `SCS_ASSERT_ALWAYS(a_no_load_in_b, clk, rst_n, !(store_we && b_count_reg != '0), "store written after b started")
    `SCS_ASSERT_NEXT(a_err_sticky, clk, rst_n, err_reg != ST_OK && state_reg != S_EMIT, err_reg == $past(err_reg), "error code changed before finish")
    `SCS_ASSERT_NEXT(a_clear_on_emit, clk, rst_n, state_reg == S_EMIT && out_free, a_count_reg == '0 && b_count_reg == '0 && result.valid, "state not cleared on emit")

endmodule

@@ verif/tb_sparse_cosine_similarity_core.sv @@
module tb_sparse_cosine_similarity_core;
    timeunit 1ns;
    timeprecision 1ps;

    import scs_pkg::*;

    localparam int          STORE_DEPTH   = MAX_ENTRIES_DEF;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 300;
    localparam int          PHASE_WORDS   = 65;
    localparam int          ROW_COUNT     = 28;
    localparam func_t       FUNC_UNUSED   = 2'd3;

    typedef struct packed {
        dot_t    dot;
        cos_t    cosine;
        count_t  ca;
        count_t  cb;
        status_t st;
    } sim_result_t;

    typedef struct packed {
        func_t              f;
        logic [31:0]        ix;
        logic signed [15:0] v;
        logic               typed;
        sim_result_t        want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_t cfg_wdata;

    scs_item_if   item_bus ();
    scs_result_if res_bus ();

    sparse_cosine_similarity_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (res_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [31:0]        store_index [STORE_DEPTH];
    logic signed [15:0] store_value [STORE_DEPTH];
    int unsigned        a_cnt = 0;
    int unsigned        b_cnt = 0;
    int unsigned        walk = 0;
    logic [31:0]        last_index = '0;
    dot_t               dot_acc = '0;
    norm_t              norm_a = '0;
    norm_t              norm_b = '0;
    status_t            err_code = ST_OK;
    cfg_t               min_norm = MIN_NORM_RESET;

    sim_result_t awaited_sims [$];

    int unsigned send_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned settings_used = 1;
    int          cycle_count = 0;

    stim_row_t directed_rows [ROW_COUNT];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic norm_t add_square(norm_t sum, logic signed [15:0] v);
        logic [63:0] sq;
        sq = 64'(longint'(v) * longint'(v));
        if (sq > 64'(NORM_MAX) - 64'(sum))
            return NORM_MAX;
        return sum + norm_t'(sq);
    endfunction

    // largest m with m*m*na*nb <= dot*dot*2^30, found by bisection
    function automatic cos_t q15_cosine(dot_t dot, norm_t na, norm_t nb);
        logic [127:0]      d;
        logic [127:0]      p;
        logic [127:0]      t;
        logic [63:0]       mag;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   mid;
        mag = (dot < 0) ? 64'(-longint'(dot)) : 64'(longint'(dot));
        d = 128'(mag) * 128'(mag);
        d = d << D_SHIFT;
        p = 128'(na) * 128'(nb);
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            t = p * 128'(mid * mid);
            if (t <= d)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (dot < 0)
            return cos_t'(-longint'(lo));
        return (lo > 32767) ? COS_MAX : cos_t'(lo);
    endfunction

    function automatic void merge_join_step(func_t f, logic [31:0] ix, logic signed [15:0] v);
        longint      prod;
        longint      s;
        logic        low_norm;
        sim_result_t r;
        case (f)
            FUNC_LOAD_A:
            begin
                if (b_cnt > 0 || (a_cnt > 0 && ix <= last_index))
                begin
                    if (err_code == ST_OK)
                        err_code = ST_ORDER;
                end
                else if (a_cnt >= STORE_DEPTH)
                begin
                    if (err_code == ST_OK)
                        err_code = ST_OVERFLOW;
                end
                else
                begin
                    store_index[a_cnt] = ix;
                    store_value[a_cnt] = v;
                    a_cnt++;
                    norm_a = add_square(norm_a, v);
                    last_index = ix;
                end
            end
            FUNC_LOAD_B:
            begin
                if (b_cnt > 0 && ix <= last_index)
                begin
                    if (err_code == ST_OK)
                        err_code = ST_ORDER;
                end
                else if (b_cnt >= STORE_DEPTH)
                begin
                    if (err_code == ST_OK)
                        err_code = ST_OVERFLOW;
                end
                else
                begin
                    while (walk < a_cnt && store_index[walk] < ix)
                        walk++;
                    if (walk < a_cnt && store_index[walk] == ix)
                    begin
                        prod = longint'(store_value[walk]) * longint'(v);
                        s = longint'(dot_acc) + prod;
                        if (s > longint'(DOT_MAX))
                            s = longint'(DOT_MAX);
                        if (s < longint'(DOT_MIN))
                            s = longint'(DOT_MIN);
                        dot_acc = dot_t'(s);
                        walk++;
                    end
                    norm_b = add_square(norm_b, v);
                    b_cnt++;
                    last_index = ix;
                end
            end
            FUNC_FINISH:
            begin
                low_norm = (norm_a < norm_t'(min_norm)) || (norm_b < norm_t'(min_norm)) ||
                           (norm_a == '0) || (norm_b == '0);
                r.dot = dot_acc;
                r.cosine = low_norm ? '0 : q15_cosine(dot_acc, norm_a, norm_b);
                r.ca = count_t'(a_cnt);
                r.cb = count_t'(b_cnt);
                r.st = (err_code != ST_OK) ? err_code : (low_norm ? ST_ZERO_NORM : ST_OK);
                awaited_sims.push_back(r);
                a_cnt = 0;
                b_cnt = 0;
                walk = 0;
                last_index = '0;
                dot_acc = '0;
                norm_a = '0;
                norm_b = '0;
                err_code = ST_OK;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic signed [15:0] pick_value(int unsigned vsel);
        case (vsel)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 511)) - 16'sd256;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'sh0001;
                    default: return 16'shFFFF;
                endcase
            end
            default: return 16'($urandom_range(0, 8191)) - 16'sd4096;
        endcase
    endfunction

    // leaves valid high so back-to-back words need no gap
    task automatic send_word(input func_t f, input logic [31:0] ix, input logic signed [15:0] v);
        while (send_pct != 0 && $urandom_range(0, 99) < send_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.func        <= f;
        item_bus.entry_index <= ix;
        item_bus.entry_value <= v;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        merge_join_step(f, ix, v);
        if (f != FUNC_UNUSED)
            words_sent++;
    endtask

    task automatic send_vector_pair();
        int unsigned n_a;
        int unsigned n_b;
        int unsigned k;
        int unsigned vsel;
        logic [31:0] base;
        logic [31:0] ix;
        logic [31:0] prev;
        n_a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        n_b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        vsel = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0: base = '0;
            1: base = 32'hFFFF_FFFF - $urandom_range(0, 200);
            default: base = $urandom;
        endcase
        ix = base;
        prev = base;
        for (k = 0; k < n_a; k++)
        begin
            if (k > 0 && $urandom_range(0, 29) == 0)
                send_word(FUNC_LOAD_A, prev - $urandom_range(0, 1), pick_value(vsel));
            send_word(FUNC_LOAD_A, ix, pick_value(vsel));
            prev = ix;
            ix = ix + $urandom_range(1, 3);
        end
        ix = base + $urandom_range(0, 2);
        for (k = 0; k < n_b; k++)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_word(FUNC_LOAD_B, prev, pick_value(vsel));
                    1: send_word(FUNC_LOAD_A, ix, pick_value(vsel));
                    default: send_word(FUNC_UNUSED, $urandom, 16'($urandom));
                endcase
            end
            send_word(FUNC_LOAD_B, ix, pick_value(vsel));
            prev = ix;
            ix = ix + $urandom_range(1, 3);
        end
        send_word(FUNC_FINISH, $urandom, 16'($urandom));
    endtask

    // a or b filled one past depth; for a, an order fault then must not replace the overflow
    task automatic fill_store(input logic into_b);
        int unsigned k;
        if (!into_b)
        begin
            for (k = 0; k <= STORE_DEPTH; k++)
                send_word(FUNC_LOAD_A, 32'(k), pick_value(0));
            send_word(FUNC_LOAD_B, 32'd1, pick_value(0));
            send_word(FUNC_LOAD_B, 32'd1000, pick_value(0));
            send_word(FUNC_LOAD_A, 32'd2000, pick_value(0));
        end
        else
        begin
            for (k = 0; k < 8; k++)
                send_word(FUNC_LOAD_A, 32'(k * 3), pick_value(0));
            for (k = 0; k <= STORE_DEPTH; k++)
                send_word(FUNC_LOAD_B, 32'(k * 2), pick_value(0));
        end
        send_word(FUNC_FINISH, $urandom, 16'($urandom));
    endtask

    task automatic set_min_norm(input cfg_t val);
        while (awaited_sims.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        min_norm = val;
        settings_used++;
    endtask

    always @(posedge clk)
    begin : result_check
        sim_result_t got;
        sim_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got = '{res_bus.dot_product, res_bus.cosine, res_bus.count_a, res_bus.count_b,
                    res_bus.status};
            if (awaited_sims.size() == 0)
                flag_mismatch($sformatf("result word with nothing awaited (dot %0d cos %0d)",
                                        got.dot, got.cosine));
            else
            begin
                want = awaited_sims.pop_front();
                if (got.dot !== want.dot)
                    flag_mismatch($sformatf("result %0d dot_product %0d, want %0d",
                                            results_seen, got.dot, want.dot));
                if (got.cosine !== want.cosine)
                    flag_mismatch($sformatf("result %0d cosine %0d, want %0d",
                                            results_seen, got.cosine, want.cosine));
                if (got.ca !== want.ca)
                    flag_mismatch($sformatf("result %0d count_a %0d, want %0d",
                                            results_seen, got.ca, want.ca));
                if (got.cb !== want.cb)
                    flag_mismatch($sformatf("result %0d count_b %0d, want %0d",
                                            results_seen, got.cb, want.cb));
                if (got.st !== want.st)
                    flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                            results_seen, got.st, want.st));
            end
            results_seen++;
        end
        res_bus.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_sims.size());
            $display("tb_sparse_cosine_similarity_core: FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned r;
        int unsigned p;
        int unsigned phase_start;
        cfg_t        settings [8];
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        item_bus.valid       <= 1'b0;
        item_bus.func        <= FUNC_LOAD_A;
        item_bus.entry_index <= '0;
        item_bus.entry_value <= '0;

        directed_rows = '{
            '{FUNC_FINISH, 32'h0, 16'sh0, 1'b1, '{48'sd0, 16'sd0, 11'd0, 11'd0, ST_ZERO_NORM}},
            '{FUNC_LOAD_A, 32'h0, 16'sh7FFF, 1'b0, '0},
            '{FUNC_LOAD_B, 32'h0, 16'sh7FFF, 1'b0, '0},
            '{FUNC_FINISH, 32'h0, 16'sh0, 1'b1,
              '{48'sd1073676289, 16'sd32767, 11'd1, 11'd1, ST_OK}},
            '{FUNC_LOAD_A, 32'd5, 16'sh8000, 1'b0, '0},
            '{FUNC_LOAD_B, 32'd5, 16'sh7FFF, 1'b0, '0},
            '{FUNC_FINISH, 32'h0, 16'sh0, 1'b1,
              '{-48'sd1073709056, 16'sh8000, 11'd1, 11'd1, ST_OK}},
            // repeated a index is dropped
            '{FUNC_LOAD_A, 32'd10, 16'sd1, 1'b0, '0},
            '{FUNC_LOAD_A, 32'd10, 16'sd2, 1'b0, '0},
            '{FUNC_FINISH, 32'h0, 16'sh0, 1'b1, '{48'sd0, 16'sd0, 11'd1, 11'd0, ST_ORDER}},
            // a word after b has started
            '{FUNC_LOAD_A, 32'd1, 16'sh1000, 1'b0, '0},
            '{FUNC_LOAD_B, 32'd1, 16'sh1000, 1'b0, '0},
            '{FUNC_LOAD_A, 32'd2, 16'sh1000, 1'b0, '0},
            '{FUNC_FINISH, 32'h0, 16'sh0, 1'b1,
              '{48'sd16777216, 16'sd32767, 11'd1, 11'd1, ST_ORDER}},
            '{FUNC_LOAD_B, 32'd7, 16'sd1, 1'b0, '0},
            '{FUNC_LOAD_B, 32'd7, 16'sd1, 1'b0, '0},
            '{FUNC_FINISH, 32'h0, 16'sh0, 1'b1, '{48'sd0, 16'sd0, 11'd0, 11'd1, ST_ORDER}},
            '{FUNC_UNUSED, 32'd123, 16'sd5, 1'b0, '0},
            '{FUNC_LOAD_A, 32'hFFFF_FFFF, 16'sd1, 1'b0, '0},
            '{FUNC_LOAD_B, 32'hFFFF_FFFF, -16'sd1, 1'b0, '0},
            '{FUNC_FINISH, 32'h0, 16'sh0, 1'b1, '{-48'sd1, 16'sh8000, 11'd1, 11'd1, ST_OK}},
            // merge pointer skips a entries with no partner
            '{FUNC_LOAD_A, 32'd2, 16'sh1000, 1'b0, '0},
            '{FUNC_LOAD_A, 32'd4, -16'sd2048, 1'b0, '0},
            '{FUNC_LOAD_A, 32'd9, 16'sh7FFF, 1'b0, '0},
            '{FUNC_LOAD_B, 32'd3, 16'sh2000, 1'b0, '0},
            '{FUNC_LOAD_B, 32'd9, -16'sd16384, 1'b0, '0},
            '{FUNC_LOAD_B, 32'd11, 16'sd5, 1'b0, '0},
            '{FUNC_FINISH, 32'hDEAD_BEEF, 16'sh5A5A, 1'b0, '0}
        };
        settings = '{16'h0000, 16'hFFFF, 16'h0001, 16'($urandom_range(2, 65534)),
                     16'hFFFF, 16'h0000, 16'($urandom_range(2, 65534)), 16'h0100};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < ROW_COUNT; r++)
        begin
            send_word(directed_rows[r].f, directed_rows[r].ix, directed_rows[r].v);
            if (directed_rows[r].typed)
            begin
                void'(awaited_sims.pop_back());
                awaited_sims.push_back(directed_rows[r].want);
            end
        end
        item_bus.valid <= 1'b0;

        for (p = 0; p < 8; p++)
        begin
            set_min_norm(settings[p]);
            case (p % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 50; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 50; end
                default: begin send_pct = 31; stall_pct = 31; end
            endcase
            if (p == 1)
                fill_store(1'b0);
            if (p == 6)
                fill_store(1'b1);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
                send_vector_pair();
            item_bus.valid <= 1'b0;
        end

        while (awaited_sims.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d words in four idling patterns over %0d min_norm_squared settings,",
                 words_sent, settings_used);
        $display("with both stores filled past depth; %0d results compared, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && awaited_sims.size() == 0)
            $display("tb_sparse_cosine_similarity_core: PASS");
        else
            $display("tb_sparse_cosine_similarity_core: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/scs_pkg.sv
design/scs_if.sv
design/scs_mul.sv
design/scs_store.sv
design/sparse_cosine_similarity_core.sv
verif/tb_sparse_cosine_similarity_core.sv
